>>> hw/rtl/assert_macros.svh
// Assertion helpers; clk and arst_n must exist in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define QPD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define QPD_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define QPD_ASSERT(lbl, prop, msg)
`define QPD_NEVER(lbl, cond, msg)
`endif

`endif

>>> hw/rtl/qpd_pkg.sv
package qpd_pkg;

	localparam logic [7:0] CH_EQ = 8'h3D;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_EQ   = 2'd1,
		PH_HELD = 2'd2
	} phase_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_input;
	} enc_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       end_of_output;
	} dec_t;

	// One queue entry: up to three decoded bytes from one input beat
	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      nbytes;
		logic            last;
	} cmd_t;

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
			(c >= 8'h61 && c <= 8'h66);
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] d;
		d = 8'h00;
		if (c >= 8'h30 && c <= 8'h39) begin
			d = c - 8'h30;
		end else if (c >= 8'h41 && c <= 8'h46) begin
			d = c - 8'h37;
		end else if (c >= 8'h61 && c <= 8'h66) begin
			d = c - 8'h57;
		end
		return d[3:0];
	endfunction

endpackage

>>> hw/rtl/qpd_front.sv
module qpd_front
	import qpd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  enc_t enc,
	output logic full,
	input  logic q_full,
	output logic q_wr,
	output cmd_t q_wdata
);

	phase_t     phase_q;
	logic [7:0] held_q;
	phase_t     phase_d;
	logic [7:0] held_d;
	logic       accept;
	logic [1:0] n;
	logic [7:0] lst [4];

	assign full   = q_full;
	assign accept = push && !q_full;

	always_comb begin
		logic [7:0] b;
		b       = enc.in_byte;
		n       = 2'd0;
		lst[0]  = 8'h00;
		lst[1]  = 8'h00;
		lst[2]  = 8'h00;
		lst[3]  = 8'h00;
		phase_d = PH_IDLE;
		held_d  = held_q;
		unique case (phase_q)
			PH_EQ: begin
				if (is_hex(b) || b == CH_CR) begin
					held_d  = b;
					phase_d = PH_HELD;
				end else begin
					lst[n] = CH_EQ;
					n      = n + 2'd1;
					if (b == CH_EQ) begin
						phase_d = PH_EQ;
					end else begin
						lst[n] = b;
						n      = n + 2'd1;
					end
				end
			end
			PH_HELD: begin
				if (held_q == CH_CR && b == CH_LF) begin
					// soft line break
				end else if (is_hex(held_q) && is_hex(b)) begin
					lst[n] = {hex_val(held_q), hex_val(b)};
					n      = n + 2'd1;
				end else begin
					lst[n] = CH_EQ;
					n      = n + 2'd1;
					lst[n] = held_q;
					n      = n + 2'd1;
					if (b == CH_EQ) begin
						phase_d = PH_EQ;
					end else begin
						lst[n] = b;
						n      = n + 2'd1;
					end
				end
			end
			default: begin
				if (b == CH_EQ) begin
					phase_d = PH_EQ;
				end else begin
					lst[n] = b;
					n      = n + 2'd1;
				end
			end
		endcase
		if (enc.end_of_input) begin
			// flush whatever escape is still open
			if (phase_d == PH_EQ) begin
				lst[n] = CH_EQ;
				n      = n + 2'd1;
			end else if (phase_d == PH_HELD) begin
				lst[n] = CH_EQ;
				n      = n + 2'd1;
				lst[n] = held_d;
				n      = n + 2'd1;
			end
			phase_d = PH_IDLE;
			held_d  = 8'h00;
		end
	end

	assign q_wr            = accept && (n != 2'd0 || enc.end_of_input);
	assign q_wdata.bytes   = {lst[2], lst[1], lst[0]};
	assign q_wdata.nbytes  = n;
	assign q_wdata.last    = enc.end_of_input;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			held_q  <= 8'h00;
		end else if (accept) begin
			phase_q <= phase_d;
			held_q  <= held_d;
		end
	end

endmodule

>>> hw/rtl/qpd_fifo.sv
`include "assert_macros.svh"

module qpd_fifo
	import qpd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  cmd_t wdata,
	input  logic rd,
	output cmd_t rdata,
	output logic full,
	output logic empty
);

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_wr;
	logic              do_rd;

	assign full  = count_q == QCNT_W'(QDEPTH);
	assign empty = count_q == '0;
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`QPD_NEVER(a_cnt_range, count_q > QCNT_W'(QDEPTH), "queue count beyond depth")
	`QPD_ASSERT(a_ptr_gap, (QPTR_W'(wptr_q - rptr_q) == count_q[QPTR_W-1:0]), "pointers disagree with count")
	`QPD_ASSERT(a_grow, (do_wr && !do_rd) |=> count_q == $past(count_q) + 1'b1, "queue count failed to grow")

endmodule

>>> hw/rtl/qpd_back.sv
`include "assert_macros.svh"

module qpd_back
	import qpd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic q_empty,
	input  cmd_t q_rdata,
	output logic q_rd,
	output logic empty,
	input  logic pop,
	output dec_t dec
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	dec_t       dec_q;
	logic [1:0] n;
	logic       last_res;
	logic       load;
	logic [7:0] cur_byte;

	// an entry with no bytes still yields one end-only result
	assign n        = (q_rdata.nbytes == 2'd0) ? 2'd1 : q_rdata.nbytes;
	assign last_res = idx_q == (n - 2'd1);
	assign load     = !q_empty && (!out_valid_q || pop);
	assign q_rd     = load && last_res;

	always_comb begin
		case (idx_q)
			2'd0:    cur_byte = q_rdata.bytes[0];
			2'd1:    cur_byte = q_rdata.bytes[1];
			2'd2:    cur_byte = q_rdata.bytes[2];
			default: cur_byte = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q       <= last_res ? 2'd0 : idx_q + 2'd1;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dec_q.out_byte      <= (q_rdata.nbytes == 2'd0) ? 8'h00 : cur_byte;
			dec_q.byte_valid    <= q_rdata.nbytes != 2'd0;
			dec_q.end_of_output <= q_rdata.last && last_res;
		end
	end

	assign empty = !out_valid_q;
	assign dec   = dec_q;

	`QPD_ASSERT(a_idx_in_range, !q_empty |-> idx_q < n, "result index past entry")
	`QPD_ASSERT(a_idx_idle, q_empty |-> idx_q == 2'd0, "result index left mid-entry")
	`QPD_ASSERT(a_fill, (!q_empty && !out_valid_q) |=> out_valid_q, "output slot not filled")

endmodule

>>> hw/rtl/quoted_printable_decoder.sv
// Quoted-printable decoder, one encoded byte per beat, up to three results per beat.
// With queue and output slot empty, a beat's first result is written into the queue
// and then registered into the output slot before it shows on dec (empty low).
// Throughput: one input beat per cycle while full is low, one result per cycle while
// pop is high; a beat's k results leave in turn, and a four-entry queue absorbs bursts.
// Reset (arst_n low, asynchronous): escape state, queue and output slot cleared.
module quoted_printable_decoder
	import qpd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  enc_t enc,
	output logic full,
	output logic empty,
	input  logic pop,
	output dec_t dec
);

	logic q_full;
	logic q_empty;
	logic q_wr;
	logic q_rd;
	cmd_t q_wdata;
	cmd_t q_rdata;

	qpd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.enc     (enc),
		.full    (full),
		.q_full  (q_full),
		.q_wr    (q_wr),
		.q_wdata (q_wdata)
	);

	qpd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wdata  (q_wdata),
		.rd     (q_rd),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	qpd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_rdata (q_rdata),
		.q_rd    (q_rd),
		.empty   (empty),
		.pop     (pop),
		.dec     (dec)
	);

endmodule

>>> sim/tb_quoted_printable_decoder.sv
`timescale 1ns / 1ps

module tb_quoted_printable_decoder;
	import qpd_pkg::*;

	localparam int RANDOM_BEATS = 300;
	localparam int STALL_LIMIT  = 1000;

	logic clk;
	logic arst_n;
	logic push;
	enc_t enc;
	logic full;
	logic empty;
	logic pop;
	dec_t dec;

	// decoder state as predicted
	phase_t     esc_phase;
	logic [7:0] esc_held;
	dec_t       beat_out[$];
	dec_t       expected_q[$];

	dec_t want_beat;
	bit   failed;
	int   beats_sent;
	int   send_calm;
	int   pop_calm;
	int   pop_hold;
	int   quiet_cycles;

	quoted_printable_decoder i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.enc   (enc),
		.full  (full),
		.empty (empty),
		.pop   (pop),
		.dec   (dec)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// {is hex digit, value}
	function automatic logic [4:0] nibble_of(input logic [7:0] c);
		if (c inside {[8'h30:8'h39]}) return {1'b1, c[3:0]};
		if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) return {1'b1, c[3:0] + 4'd9};
		return 5'b0;
	endfunction

	function automatic void emit(input logic [7:0] b);
		dec_t d;
		d.out_byte      = b;
		d.byte_valid    = 1'b1;
		d.end_of_output = 1'b0;
		beat_out.push_back(d);
	endfunction

	function automatic void take_plain(input logic [7:0] b);
		if (b == CH_EQ)
			esc_phase = PH_EQ;
		else
			emit(b);
	endfunction

	function automatic void predict_decode(input enc_t e);
		logic [4:0] hi;
		logic [4:0] lo;
		dec_t       d;
		beat_out.delete();
		hi = nibble_of(esc_held);
		lo = nibble_of(e.in_byte);
		if (esc_phase == PH_EQ) begin
			if (lo[4] || e.in_byte == CH_CR) begin
				esc_held  = e.in_byte;
				esc_phase = PH_HELD;
			end else begin
				esc_phase = PH_IDLE;
				emit(CH_EQ);
				take_plain(e.in_byte);
			end
		end else if (esc_phase == PH_HELD) begin
			esc_phase = PH_IDLE;
			if (hi[4] && lo[4]) begin
				emit({hi[3:0], lo[3:0]});
			end else if (!(esc_held == CH_CR && e.in_byte == CH_LF)) begin
				emit(CH_EQ);
				emit(esc_held);
				take_plain(e.in_byte);
			end
		end else begin
			esc_phase = PH_IDLE;
			take_plain(e.in_byte);
		end
		if (e.end_of_input) begin
			if (esc_phase == PH_EQ) begin
				emit(CH_EQ);
			end else if (esc_phase == PH_HELD) begin
				emit(CH_EQ);
				emit(esc_held);
			end
			if (beat_out.size() == 0) begin
				d = '0;
				beat_out.push_back(d);
			end
			d = beat_out.pop_back();
			d.end_of_output = 1'b1;
			beat_out.push_back(d);
			esc_phase = PH_IDLE;
			esc_held  = 8'h00;
		end
		foreach (beat_out[i]) expected_q.push_back(beat_out[i]);
	endfunction

	// mostly short gaps, a few long ones, now and then a run with none
	function automatic int pick_gap(ref int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(20, 60);
			return 0;
		end
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [7:0] rand_hex_char();
		logic [7:0] v;
		v = 8'($urandom_range(0, 15));
		if (v < 8'd10) return 8'h30 + v;
		return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 8'd10;
	endfunction

	task automatic send_beat(input logic [7:0] b, input logic eoi);
		int gap;
		gap = pick_gap(send_calm);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push             <= 1'b1;
		enc.in_byte      <= b;
		enc.end_of_input <= eoi;
		do @(posedge clk); while (full);
		predict_decode('{in_byte: b, end_of_input: eoi});
		beats_sent++;
	endtask

	task automatic send_text(input string s, input logic eoi_last);
		for (int i = 0; i < s.len(); i++)
			send_beat(s[i], eoi_last && (i == s.len() - 1));
	endtask

	task automatic test_hex_escapes();
		send_text("=4a=Ff", 1'b0);
	endtask

	// soft break closing a message leaves only the end marker
	task automatic test_soft_break();
		send_beat(CH_EQ, 1'b0);
		send_beat(CH_CR, 1'b0);
		send_beat(CH_LF, 1'b1);
	endtask

	task automatic test_bad_escapes();
		send_text("==41", 1'b0);
		send_text("=G", 1'b0);
		send_text("=4Z", 1'b0);
		send_beat(CH_EQ, 1'b0);
		send_beat(CH_CR, 1'b0);
		send_beat("X", 1'b1);
	endtask

	task automatic test_end_flush();
		send_text("=", 1'b1);
		send_text("=A", 1'b1);
		send_beat(8'h00, 1'b0);
		send_beat(8'hFF, 1'b1);
	endtask

	task automatic test_random_messages();
		logic [7:0] msg[$];
		int         stop_at;
		int         ntok;
		stop_at = beats_sent + RANDOM_BEATS;
		while (beats_sent < stop_at) begin
			if ($urandom_range(0, 9) == 0) begin
				send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
				continue;
			end
			msg.delete();
			ntok = $urandom_range(1, 8);
			repeat (ntok) begin
				case ($urandom_range(0, 9)) inside
					[0:3]: msg.push_back(8'($urandom_range(0, 255)));
					[4:5]: begin
						msg.push_back(CH_EQ);
						msg.push_back(rand_hex_char());
						msg.push_back(rand_hex_char());
					end
					6: begin
						msg.push_back(CH_EQ);
						msg.push_back(CH_CR);
						msg.push_back(CH_LF);
					end
					7: begin
						msg.push_back(CH_EQ);
						msg.push_back(8'($urandom_range(0, 255)));
						msg.push_back(8'($urandom_range(0, 255)));
					end
					8: begin
						msg.push_back(CH_EQ);
						msg.push_back(CH_CR);
						msg.push_back(8'($urandom_range(0, 255)));
					end
					default: begin
						// truncated escape
						msg.push_back(CH_EQ);
						if ($urandom_range(0, 1)) msg.push_back(rand_hex_char());
					end
				endcase
			end
			foreach (msg[i]) send_beat(msg[i], i == msg.size() - 1);
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (pop_hold > 0) begin
			pop_hold--;
			pop <= 1'b0;
		end else begin
			pop_hold = pick_gap(pop_calm);
			pop <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result beat %h", $time, dec);
				failed = 1'b1;
			end else begin
				want_beat = expected_q.pop_front();
				if (dec.out_byte !== want_beat.out_byte) begin
					$display("%0t: out_byte expected %h actual %h", $time,
						want_beat.out_byte, dec.out_byte);
					failed = 1'b1;
				end
				if (dec.byte_valid !== want_beat.byte_valid) begin
					$display("%0t: byte_valid expected %b actual %b", $time,
						want_beat.byte_valid, dec.byte_valid);
					failed = 1'b1;
				end
				if (dec.end_of_output !== want_beat.end_of_output) begin
					$display("%0t: end_of_output expected %b actual %b", $time,
						want_beat.end_of_output, dec.end_of_output);
					failed = 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
				$display("** quoted_printable_decoder: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		arst_n       = 1'b0;
		push         = 1'b0;
		enc          = '0;
		pop          = 1'b0;
		failed       = 1'b0;
		beats_sent   = 0;
		send_calm    = 0;
		pop_calm     = 0;
		pop_hold     = 0;
		quiet_cycles = 0;
		esc_phase    = PH_IDLE;
		esc_held     = 8'h00;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_hex_escapes();
		test_soft_break();
		test_bad_escapes();
		test_end_flush();
		test_random_messages();

		push <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (!failed && expected_q.size() == 0)
			$display("** quoted_printable_decoder: PASSED **");
		else
			$display("** quoted_printable_decoder: FAILED **");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/qpd_pkg.sv
hw/rtl/qpd_front.sv
hw/rtl/qpd_fifo.sv
hw/rtl/qpd_back.sv
hw/rtl/quoted_printable_decoder.sv
sim/tb_quoted_printable_decoder.sv
